// ===== design/quoted_pair_escape_decoder_top_assert.svh =====
// assertion macros shared by the queue and serializer modules
`ifndef QUOTED_PAIR_ESCAPE_DECODER_TOP_ASSERT_SVH
`define QUOTED_PAIR_ESCAPE_DECODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// condition implies consequence in the same cycle
`define QPED_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("qped assertion failed");

// condition implies consequence in the next cycle
`define QPED_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("qped assertion failed");

`else

`define QPED_ASSERT_SAME(label, clk, rst_n, cond, cons)
`define QPED_ASSERT_NEXT(label, clk, rst_n, cond, cons)

`endif

`endif

// ===== design/qped_pkg.sv =====
`default_nettype none

package qped_pkg;

    // result kinds
    typedef enum logic [2:0] {
        KIND_KEY    = 3'd0,
        KIND_VALUE  = 3'd1,
        KIND_ACCEPT = 3'd2,
        KIND_SKIP   = 3'd3,
        KIND_ERROR  = 3'd4
    } t_kind;

    // one result beat
    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_value;
    } t_res;

    // results of one input beat, one or two
    typedef struct packed {
        logic two;
        t_res r0;
        t_res r1;
    } t_bundle;

    // queue between front and back, depth a power of two
    localparam int QPED_FIFO_DEPTH = 4;
    localparam int QPED_PTR_W      = $clog2(QPED_FIFO_DEPTH);
    localparam int QPED_CNT_W      = QPED_PTR_W + 1;

    // characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // white space: space, tab, lf, vt, ff, cr
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

    // {valid, digit value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    // {valid, byte} for single-character escapes
    function automatic logic [8:0] simple_esc(input logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            8'h30:     r = {1'b1, 8'd0};
            8'h61:     r = {1'b1, 8'd7};
            8'h62:     r = {1'b1, 8'd8};
            8'h66:     r = {1'b1, 8'd12};
            8'h6E:     r = {1'b1, 8'd10};
            8'h72:     r = {1'b1, 8'd13};
            8'h74:     r = {1'b1, 8'd9};
            8'h76:     r = {1'b1, 8'd11};
            CH_BSL:    r = {1'b1, CH_BSL};
            CH_SQUOTE: r = {1'b1, CH_SQUOTE};
            CH_QUOTE:  r = {1'b1, CH_QUOTE};
            default:   r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/quoted_pair_escape_decoder_top.sv =====
// channel  | direction | handshake    | payload
// ---------+-----------+--------------+----------------------------------------
// input    | in        | push / full  | i_char_byte, i_end_of_line
// result   | out       | empty / pop  | o_kind, o_byte_value, o_last
//
// the front takes one input beat per cycle while full is low and classifies it
// in that cycle; its one or two results go into a four-entry queue
// the back gives one result beat per cycle while pop keeps up, so a beat
// with two results (flushed octal escape plus a character, or a byte plus the
// line status) yields two result beats; the queue absorbs bursts of such beats
// a result passes through a queue entry and the output register to the ports
// reset is synchronous and clears the line state, queue and output register
// full rises only when the queue holds four entries; a stalled pop fills it
`default_nettype none

module quoted_pair_escape_decoder_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_char_byte,
    input  wire logic       i_end_of_line,
    output logic            empty,
    input  wire logic       pop,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_byte_value,
    output logic            o_last
);

    qped_pkg::t_bundle wr_data;
    qped_pkg::t_bundle rd_data;
    logic              wr;
    logic              rd;
    logic              q_empty;

    // parse and decode
    qped_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_char_byte   (i_char_byte),
        .i_end_of_line (i_end_of_line),
        .o_bundle      (wr_data),
        .o_wr          (wr)
    );

    // queue between front and back
    qped_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_wr_data (wr_data),
        .o_full    (full),
        .i_rd      (rd),
        .o_rd_data (rd_data),
        .o_empty   (q_empty)
    );

    // result serializer
    qped_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_empty   (q_empty),
        .i_rd_data    (rd_data),
        .o_rd         (rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_kind       (o_kind),
        .o_byte_value (o_byte_value),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// ===== design/qped_front.sv =====
`default_nettype none

module qped_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic              i_full,
    input  wire logic [7:0]        i_char_byte,
    input  wire logic              i_end_of_line,
    output qped_pkg::t_bundle      o_bundle,
    output logic                   o_wr
);

    typedef enum logic [3:0] {
        PH_LEAD      = 4'd0,
        PH_KEY       = 4'd1,
        PH_POSTKEY   = 4'd2,
        PH_POSTCOMMA = 4'd3,
        PH_VALUE     = 4'd4,
        PH_DONE      = 4'd5,
        PH_SKIP      = 4'd6
    } t_phase;

    typedef enum logic [1:0] {
        EK_NONE = 2'd0,
        EK_BSL  = 2'd1,
        EK_HEX  = 2'd2,
        EK_OCT  = 2'd3
    } t_esc;

    t_phase      r_phase, n_phase;
    t_esc        r_ek, n_ek;
    logic [7:0]  r_acc, n_acc;
    logic [1:0]  r_dig, n_dig;
    logic        r_err, n_err;

    logic        accept;
    logic        e0_v, e1_v;
    qped_pkg::t_res e0, e1;
    qped_pkg::t_kind bk;
    t_phase      close_ph;
    logic [4:0]  hv;
    logic [8:0]  sv;
    logic [7:0]  oct_acc;
    logic [7:0]  hex_acc;
    logic [7:0]  c;

    assign accept = i_push && !i_full;
    assign c      = i_char_byte;

    // next state and results of one beat
    always_comb begin
        n_phase  = r_phase;
        n_ek     = r_ek;
        n_acc    = r_acc;
        n_dig    = r_dig;
        n_err    = r_err;
        e0_v     = 1'b0;
        e1_v     = 1'b0;
        e0       = '{kind: qped_pkg::KIND_KEY, byte_value: 8'd0};
        e1       = '{kind: qped_pkg::KIND_KEY, byte_value: 8'd0};
        bk       = (r_phase == PH_KEY) ? qped_pkg::KIND_KEY : qped_pkg::KIND_VALUE;
        close_ph = (r_phase == PH_KEY) ? PH_POSTKEY : PH_DONE;
        hv       = qped_pkg::hex_val(c);
        sv       = qped_pkg::simple_esc(c);
        oct_acc  = {r_acc[4:0], c[2:0]};
        hex_acc  = {r_acc[3:0], hv[3:0]};

        if (i_end_of_line) begin
            // status on end of line, then back to reset values
            e0_v = 1'b1;
            e0   = '{kind: qped_pkg::KIND_SKIP, byte_value: 8'd0};
            if (r_err) begin
                e0.kind = qped_pkg::KIND_ERROR;
            end else if (r_phase == PH_KEY || r_phase == PH_VALUE) begin
                if (r_ek == EK_BSL || r_ek == EK_HEX) begin
                    e0.kind = qped_pkg::KIND_ERROR;
                end else if (r_ek == EK_OCT) begin
                    if (r_dig == 2'd2 || r_acc == 8'd0) begin
                        e0   = '{kind: bk, byte_value: r_acc};
                        e1_v = 1'b1;
                        e1   = '{kind: qped_pkg::KIND_SKIP, byte_value: 8'd0};
                    end else begin
                        e0.kind = qped_pkg::KIND_ERROR;
                    end
                end
            end else if (r_phase == PH_DONE) begin
                e0.kind = qped_pkg::KIND_ACCEPT;
            end
            n_phase = PH_LEAD;
            n_ek    = EK_NONE;
            n_acc   = 8'd0;
            n_dig   = 2'd0;
            n_err   = 1'b0;
        end else if (!r_err) begin
            unique case (r_phase)
                PH_LEAD: begin
                    if (c == qped_pkg::CH_QUOTE) n_phase = PH_KEY;
                    else if (!qped_pkg::is_ws(c)) n_phase = PH_SKIP;
                end
                PH_POSTKEY: begin
                    if (c == qped_pkg::CH_COMMA) n_phase = PH_POSTCOMMA;
                    else if (!qped_pkg::is_ws(c)) n_phase = PH_SKIP;
                end
                PH_POSTCOMMA: begin
                    if (c == qped_pkg::CH_QUOTE) n_phase = PH_VALUE;
                    else if (!qped_pkg::is_ws(c)) n_phase = PH_SKIP;
                end
                PH_KEY, PH_VALUE: begin
                    unique case (r_ek)
                        EK_NONE: begin
                            if (c == qped_pkg::CH_QUOTE) n_phase = close_ph;
                            else if (c == qped_pkg::CH_BSL) n_ek = EK_BSL;
                            else begin
                                e0_v = 1'b1;
                                e0   = '{kind: bk, byte_value: c};
                            end
                        end
                        EK_BSL: begin
                            if (c == qped_pkg::CH_X) begin
                                n_ek  = EK_HEX;
                                n_dig = 2'd0;
                                n_acc = 8'd0;
                            end else if (qped_pkg::is_oct(c)) begin
                                n_ek  = EK_OCT;
                                n_dig = 2'd1;
                                n_acc = {5'd0, c[2:0]};
                            end else if (sv[8]) begin
                                e0_v  = 1'b1;
                                e0    = '{kind: bk, byte_value: sv[7:0]};
                                n_ek  = EK_NONE;
                                n_dig = 2'd0;
                                n_acc = 8'd0;
                            end else begin
                                n_err = 1'b1;
                                n_ek  = EK_NONE;
                                n_dig = 2'd0;
                                n_acc = 8'd0;
                            end
                        end
                        EK_HEX: begin
                            if (!hv[4]) begin
                                n_err = 1'b1;
                                n_ek  = EK_NONE;
                                n_dig = 2'd0;
                                n_acc = 8'd0;
                            end else if (r_dig == 2'd1) begin
                                e0_v  = 1'b1;
                                e0    = '{kind: bk, byte_value: hex_acc};
                                n_ek  = EK_NONE;
                                n_dig = 2'd0;
                                n_acc = 8'd0;
                            end else begin
                                n_acc = hex_acc;
                                n_dig = r_dig + 2'd1;
                            end
                        end
                        EK_OCT: begin
                            if (qped_pkg::is_oct(c)) begin
                                if (r_dig == 2'd1 && oct_acc < 8'd32) begin
                                    // first digit 0 to 3: a third digit may follow
                                    n_acc = oct_acc;
                                    n_dig = 2'd2;
                                end else begin
                                    e0_v  = 1'b1;
                                    e0    = '{kind: bk, byte_value: oct_acc};
                                    n_ek  = EK_NONE;
                                    n_dig = 2'd0;
                                    n_acc = 8'd0;
                                end
                            end else if (r_dig == 2'd2 || r_acc == 8'd0) begin
                                // flush pending octal, then handle the character
                                e0_v  = 1'b1;
                                e0    = '{kind: bk, byte_value: r_acc};
                                n_ek  = EK_NONE;
                                n_dig = 2'd0;
                                n_acc = 8'd0;
                                if (c == qped_pkg::CH_QUOTE) n_phase = close_ph;
                                else if (c == qped_pkg::CH_BSL) n_ek = EK_BSL;
                                else begin
                                    e1_v = 1'b1;
                                    e1   = '{kind: bk, byte_value: c};
                                end
                            end else begin
                                n_err = 1'b1;
                                n_ek  = EK_NONE;
                                n_dig = 2'd0;
                                n_acc = 8'd0;
                            end
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // queue write
    assign o_wr     = accept && e0_v;
    assign o_bundle = '{two: e1_v, r0: e0, r1: e1};

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_ek    <= EK_NONE;
            r_acc   <= 8'd0;
            r_dig   <= 2'd0;
            r_err   <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_ek    <= n_ek;
            r_acc   <= n_acc;
            r_dig   <= n_dig;
            r_err   <= n_err;
        end
    end

endmodule

`default_nettype wire

// ===== design/qped_fifo.sv =====
`default_nettype none

`include "quoted_pair_escape_decoder_top_assert.svh"

module qped_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  wire qped_pkg::t_bundle i_wr_data,
    output logic                   o_full,
    input  wire logic              i_rd,
    output qped_pkg::t_bundle      o_rd_data,
    output logic                   o_empty
);

    qped_pkg::t_bundle r_mem [qped_pkg::QPED_FIFO_DEPTH];
    logic [qped_pkg::QPED_PTR_W-1:0] r_wr_ptr;
    logic [qped_pkg::QPED_PTR_W-1:0] r_rd_ptr;
    logic [qped_pkg::QPED_CNT_W-1:0] r_count;
    logic [qped_pkg::QPED_CNT_W-1:0] cnt_max;
    logic [qped_pkg::QPED_CNT_W-1:0] cnt_one;
    logic wr_en, rd_en;

    assign cnt_max   = qped_pkg::QPED_CNT_W'(qped_pkg::QPED_FIFO_DEPTH);
    assign cnt_one   = qped_pkg::QPED_CNT_W'(1);
    assign o_full    = (r_count == cnt_max);
    assign o_empty   = (r_count == '0);
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) r_wr_ptr <= r_wr_ptr + qped_pkg::QPED_PTR_W'(1);
            if (rd_en) r_rd_ptr <= r_rd_ptr + qped_pkg::QPED_PTR_W'(1);
            if (wr_en && !rd_en) r_count <= r_count + cnt_one;
            else if (rd_en && !wr_en) r_count <= r_count - cnt_one;
        end
    end

    // checks
    `QPED_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= cnt_max)
    `QPED_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, wr_en && !rd_en, r_count == $past(r_count) + cnt_one)
    `QPED_ASSERT_NEXT(a_count_down, i_clk, i_rst_n, rd_en && !wr_en, r_count == $past(r_count) - cnt_one)

endmodule

`default_nettype wire

// ===== design/qped_back.sv =====
`default_nettype none

`include "quoted_pair_escape_decoder_top_assert.svh"

module qped_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_empty,
    input  wire qped_pkg::t_bundle i_rd_data,
    output logic                   o_rd,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic [2:0]             o_kind,
    output logic [7:0]             o_byte_value,
    output logic                   o_last
);

    logic           r_valid;
    logic           r_last;
    qped_pkg::t_res r_res;
    logic           r_pend_v;
    qped_pkg::t_res r_pend;
    logic           load;
    logic           is_status;
    logic           pend_out;

    // output slot free or being taken
    assign load = !r_valid || i_pop;
    assign o_rd = load && !r_pend_v && !i_rd_empty;

    // output register and held second result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_pend_v <= 1'b0;
        end else if (load) begin
            if (r_pend_v) begin
                r_valid  <= 1'b1;
                r_res    <= r_pend;
                r_last   <= 1'b1;
                r_pend_v <= 1'b0;
            end else if (!i_rd_empty) begin
                r_valid  <= 1'b1;
                r_res    <= i_rd_data.r0;
                r_last   <= !i_rd_data.two;
                r_pend_v <= i_rd_data.two;
                r_pend   <= i_rd_data.r1;
            end else begin
                r_valid  <= 1'b0;
            end
        end
    end

    assign o_empty      = !r_valid;
    assign o_kind       = r_res.kind;
    assign o_byte_value = r_res.byte_value;
    assign o_last       = r_last;

    // line status shown, second result about to move up
    assign is_status = (r_res.kind == qped_pkg::KIND_ACCEPT)
                    || (r_res.kind == qped_pkg::KIND_SKIP)
                    || (r_res.kind == qped_pkg::KIND_ERROR);
    assign pend_out  = r_valid && i_pop && r_pend_v;

    // checks
    `QPED_ASSERT_SAME(a_pend_shows_first, i_clk, i_rst_n, r_pend_v, r_valid && !r_last)
    `QPED_ASSERT_SAME(a_status_last, i_clk, i_rst_n, r_valid && is_status, r_last)
    `QPED_ASSERT_NEXT(a_second_follows, i_clk, i_rst_n, pend_out, r_valid && r_last && !r_pend_v)

endmodule

`default_nettype wire
